>>> hw/rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, constants and helpers for the go-back-N sender window.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // Default structural parameters
    localparam int GBN_WINDOW_MAX = 32;
    localparam int GBN_SEQ_BITS   = 24;

    // Fixed field widths of the channels
    localparam int SEQ_W      = 24;
    localparam int CNT_W      = 24;
    localparam int TIME_W     = 32;
    localparam int WLIM_W     = 6;
    localparam int TMO_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    // Configuration reset values
    localparam logic [CNT_W-1:0]  TOTAL_RST   = 24'd100000;
    localparam logic [WLIM_W-1:0] WINDOW_RST  = 6'd32;
    localparam logic [TMO_W-1:0]  TIMEOUT_RST = 16'd100;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_NEW    = 2'd0,
        KIND_RESEND = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    // One result item
    typedef struct packed {
        kind_t             kind;
        logic [SEQ_W-1:0]  seq_out;
        logic [SEQ_W-1:0]  window_base;
        logic [CNT_W-1:0]  sent_total;
        logic [CNT_W-1:0]  acked_total;
        logic [CNT_W-1:0]  resent_total;
        logic              done_res;
        logic              last;
    } res_t;

    // Which slot the acknowledge-mark read port looks at
    typedef enum logic [1:0] {
        MSEL_ACK  = 2'd0,
        MSEL_BASE = 2'd1,
        MSEL_WALK = 2'd2
    } mark_sel_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACK_MARK,
        ST_SLIDE,
        ST_SEND,
        ST_STAMP_WAIT,
        ST_TIMEOUT,
        ST_RESEND,
        ST_END,
        ST_STATUS,
        ST_FINAL
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic      load;
        logic      ack_mark;
        logic      slide;
        logic      send;
        logic      walk_start;
        logic      walk_step;
        logic      resend;
        logic      emit_status;
        logic      final_push;
        mark_sel_t mark_sel;
    } gbn_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic ack_in_range;
        logic mark_bit;
        logic slide_ok;
        logic send_ok;
        logic done;
        logic timed_out;
        logic walk_more;
        logic emit_ok;
        logic out_free;
        logic pend_valid;
    } gbn_stat_t;

    // Counter increment that holds at full scale
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

>>> hw/rtl/gbn_if.sv
// ----------------------------------------------------------------------------
// gbn channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface gbn_req_if import gbn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [SEQ_W-1:0] ack_seq;

    modport source (output valid, output mode, output ack_seq, input ready);
    modport sink   (input valid, input mode, input ack_seq, output ready);
endinterface

interface gbn_res_if import gbn_pkg::*; ();
    logic             valid;
    logic             ready;
    kind_t            kind;
    logic [SEQ_W-1:0] seq_out;
    logic [SEQ_W-1:0] window_base;
    logic [CNT_W-1:0] sent_total;
    logic [CNT_W-1:0] acked_total;
    logic [CNT_W-1:0] resent_total;
    logic             done_res;
    logic             last;

    modport source (output valid, output kind, output seq_out, output window_base,
                    output sent_total, output acked_total, output resent_total,
                    output done_res, output last, input ready);
    modport sink   (input valid, input kind, input seq_out, input window_base,
                    input sent_total, input acked_total, input resent_total,
                    input done_res, input last, output ready);
endinterface

interface gbn_cfg_if import gbn_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/go_back_n_sender_window.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_window: one item in flight; an ack marks its entry and slides
// the base (an out-of-window ack gives a status-only result), a tick sends new
// packets, checks the timeout and resends the window, and each item ends with a
// closing result. The next item is taken in the cycle after the closing result;
// result stalls hold the sequence. Async active-low reset empties the window,
// clears the marks, counters and time, and loads the register defaults.
// ----------------------------------------------------------------------------
module go_back_n_sender_window import gbn_pkg::*;
#(
    parameter int WINDOW_MAX = GBN_WINDOW_MAX,
    parameter int SEQ_BITS   = GBN_SEQ_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    gbn_req_if.sink   req,
    gbn_res_if.source res,
    gbn_cfg_if.sink   cfg
);

    gbn_cmd_t  cmd;
    gbn_stat_t stat;
    logic      in_ready;

    assign req.ready = in_ready;

    // Item sequencer
    gbn_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_mode  (req.mode),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Window datapath
    gbn_dpath #(
        .WINDOW_MAX (WINDOW_MAX),
        .SEQ_BITS   (SEQ_BITS)
    ) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_mode    (req.mode),
        .in_ack_seq (req.ack_seq),
        .cmd        (cmd),
        .stat       (stat),
        .res        (res),
        .cfg        (cfg)
    );

    // A new item never starts over a staged result
    a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> !stat.pend_valid)
        else $error("input accepted while a result is still staged");

    // At most one result is produced per cycle
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.send, cmd.resend, cmd.emit_status, cmd.final_push}))
        else $error("more than one result produced in a cycle");

    // The closing transfer only moves a staged result into a free output
    a_final_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.final_push |-> (stat.pend_valid && stat.out_free))
        else $error("final result pushed without a staged result or free output");

    // A new packet is issued only while the window has room
    a_send_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.send |-> (stat.send_ok && !stat.done))
        else $error("new packet issued outside the window");

endmodule

>>> hw/rtl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer for one input item: ack mark and base slide, or tick send,
// timeout check and window resend walk, then the closing result.
// ----------------------------------------------------------------------------
module gbn_ctrl import gbn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_mode,
    output logic      in_ready,
    input  gbn_stat_t stat,
    output gbn_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_mode ? ST_ACK_MARK : ST_SEND;
                end
            end
            ST_ACK_MARK:
            begin
                state_next = stat.ack_in_range ? ST_SLIDE : ST_STATUS;
            end
            ST_SLIDE:
            begin
                if (!(stat.slide_ok && stat.mark_bit))
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_SEND:
            begin
                if (stat.done)
                begin
                    state_next = ST_END;
                end
                else if (!stat.send_ok)
                begin
                    state_next = ST_STAMP_WAIT;
                end
            end
            ST_STAMP_WAIT:
            begin
                state_next = ST_TIMEOUT;
            end
            ST_TIMEOUT:
            begin
                state_next = stat.timed_out ? ST_RESEND : ST_END;
            end
            ST_RESEND:
            begin
                if (!stat.walk_more)
                begin
                    state_next = ST_END;
                end
            end
            ST_END:
            begin
                state_next = stat.pend_valid ? ST_FINAL : ST_STATUS;
            end
            ST_STATUS:
            begin
                if (stat.emit_ok)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        cmd.mark_sel = MSEL_BASE;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_ACK_MARK:
            begin
                cmd.mark_sel = MSEL_ACK;
                cmd.ack_mark = stat.ack_in_range;
            end
            ST_SLIDE:
            begin
                cmd.mark_sel = MSEL_BASE;
                cmd.slide    = stat.slide_ok && stat.mark_bit;
            end
            ST_SEND:
            begin
                cmd.send = !stat.done && stat.send_ok && stat.emit_ok;
            end
            ST_TIMEOUT:
            begin
                cmd.walk_start = stat.timed_out;
            end
            ST_RESEND:
            begin
                cmd.mark_sel = MSEL_WALK;
                if (stat.walk_more)
                begin
                    if (stat.mark_bit)
                    begin
                        cmd.walk_step = 1'b1;
                    end
                    else if (stat.emit_ok)
                    begin
                        cmd.resend    = 1'b1;
                        cmd.walk_step = 1'b1;
                    end
                end
            end
            ST_STATUS:
            begin
                cmd.emit_status = stat.emit_ok;
            end
            ST_FINAL:
            begin
                cmd.final_push = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> hw/rtl/gbn_dpath.sv
// ----------------------------------------------------------------------------
// gbn_dpath
// Window registers, acknowledge marks, send stamp memory, counters,
// configuration registers and the two-deep result staging.
// ----------------------------------------------------------------------------
module gbn_dpath import gbn_pkg::*;
#(
    parameter int WINDOW_MAX = GBN_WINDOW_MAX,
    parameter int SEQ_BITS   = GBN_SEQ_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_mode,
    input  logic [SEQ_W-1:0] in_ack_seq,
    input  gbn_cmd_t         cmd,
    output gbn_stat_t        stat,
    gbn_res_if.source        res,
    gbn_cfg_if.sink          cfg
);

    localparam int SLOT_W = $clog2(WINDOW_MAX);
    localparam int CMP_W  = (SEQ_BITS > CNT_W) ? SEQ_BITS : CNT_W;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_MAX - 1);
    localparam logic [SLOT_W:0]   SLOT_SPAN = (SLOT_W + 1)'(WINDOW_MAX);
    localparam logic [CMP_W-1:0]  SEQ_TOP   = CMP_W'({SEQ_BITS{1'b1}});

    // Configuration registers
    logic [CNT_W-1:0]  total_reg;
    logic [WLIM_W-1:0] wlim_reg;
    logic [TMO_W-1:0]  tmo_reg;

    // Window state
    logic [SEQ_BITS-1:0] base_reg, base_next;
    logic [SEQ_BITS-1:0] next_reg, next_next;
    logic [SLOT_W-1:0]   base_slot_reg, base_slot_next;
    logic [SLOT_W-1:0]   next_slot_reg, next_slot_next;
    logic [WINDOW_MAX-1:0] marks_reg, marks_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [CNT_W-1:0]    sent_reg, sent_next;
    logic [CNT_W-1:0]    acked_reg, acked_next;
    logic [CNT_W-1:0]    resent_reg, resent_next;

    // Item and walk payload
    logic [SEQ_BITS-1:0] ack_reg;
    logic [SEQ_BITS-1:0] q_reg;
    logic [SLOT_W-1:0]   q_slot_reg;

    // Send stamp memory
    logic [TIME_W-1:0] stamp_mem [WINDOW_MAX];
    logic [TIME_W-1:0] stamp_rd_reg;
    logic              stamp_we;
    logic [SLOT_W-1:0] stamp_waddr;

    // Result staging
    res_t pend_reg, pend_next;
    logic pend_valid_reg, pend_valid_next;
    res_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    // Derived values
    logic [SEQ_BITS-1:0] tot;
    logic [CMP_W-1:0]    tot_ext;
    logic [WLIM_W-1:0]   lim;
    logic [SEQ_BITS-1:0] outstanding;
    logic [SEQ_BITS-1:0] ack_dist;
    logic [SLOT_W:0]     ack_sum;
    logic [SLOT_W-1:0]   ack_slot;
    logic [SLOT_W-1:0]   mark_addr;
    logic                mark_bit;
    logic [TIME_W-1:0]   elapsed;
    logic                out_free;
    logic                emit_ok;
    logic                emit;
    res_t                new_res;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
    endfunction

    // Always take register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RST;
            wlim_reg  <= WINDOW_RST;
            tmo_reg   <= TIMEOUT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_TOTAL:   total_reg <= cfg.data[CNT_W-1:0];
                CFG_WINDOW:  wlim_reg  <= cfg.data[WLIM_W-1:0];
                CFG_TIMEOUT: tmo_reg   <= cfg.data[TMO_W-1:0];
                default:     total_reg <= total_reg;
            endcase
        end
    end

    // Cap the total at the sequence space, clamp the window limit
    always_comb
    begin
        tot_ext = CMP_W'(total_reg);
        tot     = SEQ_BITS'((tot_ext > SEQ_TOP) ? SEQ_TOP : tot_ext);
        lim     = wlim_reg;
        if (wlim_reg == '0)
        begin
            lim = WLIM_W'(1);
        end
        else if (wlim_reg > WLIM_W'(WINDOW_MAX))
        begin
            lim = WLIM_W'(WINDOW_MAX);
        end
    end

    // Window tests
    assign outstanding = next_reg - base_reg;
    assign ack_dist    = ack_reg - base_reg;
    assign ack_sum     = {1'b0, base_slot_reg} + {1'b0, ack_dist[SLOT_W-1:0]};
    assign ack_slot    = (ack_sum >= SLOT_SPAN) ? SLOT_W'(ack_sum - SLOT_SPAN)
                                                : ack_sum[SLOT_W-1:0];

    // Single read port on the acknowledge marks
    always_comb
    begin
        case (cmd.mark_sel)
            MSEL_ACK:  mark_addr = ack_slot;
            MSEL_BASE: mark_addr = base_slot_reg;
            MSEL_WALK: mark_addr = q_slot_reg;
            default:   mark_addr = base_slot_reg;
        endcase
    end
    assign mark_bit = marks_reg[mark_addr];

    assign elapsed  = now_reg - stamp_rd_reg;
    assign out_free = !out_valid_reg || res.ready;
    assign emit_ok  = !pend_valid_reg || out_free;
    assign emit     = cmd.send || cmd.resend || cmd.emit_status;

    always_comb
    begin
        stat.ack_in_range = (ack_reg >= base_reg) && (ack_reg < next_reg);
        stat.mark_bit     = mark_bit;
        stat.slide_ok     = base_reg < next_reg;
        stat.send_ok      = (next_reg < tot) && (outstanding < SEQ_BITS'(lim));
        stat.done         = base_reg >= tot;
        stat.timed_out    = (base_reg < next_reg) && (elapsed >= TIME_W'(tmo_reg));
        stat.walk_more    = q_reg < next_reg;
        stat.emit_ok      = emit_ok;
        stat.out_free     = out_free;
        stat.pend_valid   = pend_valid_reg;
    end

    // Window and counter updates
    always_comb
    begin
        base_next      = base_reg;
        base_slot_next = base_slot_reg;
        next_next      = next_reg;
        next_slot_next = next_slot_reg;
        marks_next     = marks_reg;
        now_next       = now_reg;
        sent_next      = sent_reg;
        acked_next     = acked_reg;
        resent_next    = resent_reg;

        // Advance time on a tick
        if (cmd.load && !in_mode)
        begin
            now_next = now_reg + TIME_W'(1);
        end
        // Mark an acknowledged entry once
        if (cmd.ack_mark && !mark_bit)
        begin
            marks_next[ack_slot] = 1'b1;
            acked_next           = sat_inc(acked_reg);
        end
        // Slide the base over an acknowledged entry
        if (cmd.slide)
        begin
            base_next      = base_reg + SEQ_BITS'(1);
            base_slot_next = slot_inc(base_slot_reg);
        end
        // Issue a new sequence number
        if (cmd.send)
        begin
            marks_next[next_slot_reg] = 1'b0;
            sent_next      = sat_inc(sent_reg);
            next_next      = next_reg + SEQ_BITS'(1);
            next_slot_next = slot_inc(next_slot_reg);
        end
        if (cmd.resend)
        begin
            resent_next = sat_inc(resent_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            base_slot_reg <= '0;
            next_reg      <= '0;
            next_slot_reg <= '0;
            marks_reg     <= '0;
            now_reg       <= '0;
            sent_reg      <= '0;
            acked_reg     <= '0;
            resent_reg    <= '0;
        end
        else
        begin
            base_reg      <= base_next;
            base_slot_reg <= base_slot_next;
            next_reg      <= next_next;
            next_slot_reg <= next_slot_next;
            marks_reg     <= marks_next;
            now_reg       <= now_next;
            sent_reg      <= sent_next;
            acked_reg     <= acked_next;
            resent_reg    <= resent_next;
        end
    end

    // Latch the acknowledged number, step the resend walk
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ack_reg <= SEQ_BITS'(in_ack_seq);
        end
        if (cmd.walk_start)
        begin
            q_reg      <= base_reg;
            q_slot_reg <= base_slot_reg;
        end
        else if (cmd.walk_step)
        begin
            q_reg      <= q_reg + SEQ_BITS'(1);
            q_slot_reg <= slot_inc(q_slot_reg);
        end
    end

    // Stamp memory: one write port, registered read at the base slot
    assign stamp_we    = cmd.send || cmd.resend;
    assign stamp_waddr = cmd.send ? next_slot_reg : q_slot_reg;

    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_waddr] <= now_reg;
        end
        stamp_rd_reg <= stamp_mem[base_slot_reg];
    end

    // Build the result with the state right after its action
    always_comb
    begin
        new_res.kind         = KIND_STATUS;
        new_res.seq_out      = '0;
        if (cmd.send)
        begin
            new_res.kind    = KIND_NEW;
            new_res.seq_out = SEQ_W'(next_reg);
        end
        else if (cmd.resend)
        begin
            new_res.kind    = KIND_RESEND;
            new_res.seq_out = SEQ_W'(q_reg);
        end
        new_res.window_base  = SEQ_W'(base_next);
        new_res.sent_total   = sent_next;
        new_res.acked_total  = acked_next;
        new_res.resent_total = resent_next;
        new_res.done_res     = base_next >= tot;
        new_res.last         = 1'b0;
    end

    // Staging: hold one result until it is known whether another follows
    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !res.ready;

        if (emit)
        begin
            pend_next       = new_res;
            pend_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
        end
        else if (cmd.final_push)
        begin
            out_next        = pend_reg;
            out_next.last   = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // Drive the result channel from the output register
    assign res.valid        = out_valid_reg;
    assign res.kind         = out_reg.kind;
    assign res.seq_out      = out_reg.seq_out;
    assign res.window_base  = out_reg.window_base;
    assign res.sent_total   = out_reg.sent_total;
    assign res.acked_total  = out_reg.acked_total;
    assign res.resent_total = out_reg.resent_total;
    assign res.done_res     = out_reg.done_res;
    assign res.last         = out_reg.last;

endmodule
